### src/sps_pkg.sv
// shared types and constants of the sampling pump sequencer
`default_nettype none

package sps_pkg;

   localparam int unsigned REQ_DATA_W = 112;
   localparam int unsigned REQ_USER_W = 3;
   localparam int unsigned RSP_DATA_W = 32;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [31:0] MANUAL_LIMIT_MS = 32'd1800000;
   localparam logic [31:0] SAMPLE_GAP_MS = 32'd300000;
   localparam logic [7:0] DUTY_MAX = 8'd255;

   typedef enum logic [2:0] {
      CMD_TICK = 3'd0,
      CMD_START = 3'd1,
      CMD_STOP = 3'd2,
      CMD_ESTOP = 3'd3,
      CMD_FLOW = 3'd4,
      CMD_RUN_MODE = 3'd5,
      CMD_DURATION = 3'd6,
      CMD_HEARTBEAT = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_OFF = 2'd0,
      MODE_MANUAL = 2'd1,
      MODE_GAS = 2'd2,
      MODE_TIMED = 2'd3
   } run_mode_type;

   typedef enum logic [2:0] {
      CSR_GAS_THRESHOLD = 3'd0,
      CSR_WINDOW_START = 3'd1,
      CSR_WINDOW_END = 3'd2,
      CSR_DUAL_PUMP = 3'd3,
      CSR_LINK_TIMEOUT = 3'd4
   } csr_index_type;

   localparam int unsigned EV_DURATION = 0;
   localparam int unsigned EV_MANUAL_LIMIT = 1;
   localparam int unsigned EV_WINDOW_EXIT = 2;
   localparam int unsigned EV_GAS_START = 3;
   localparam int unsigned EV_TIMED_START = 4;
   localparam int unsigned EV_DEFLATE_REFUSED = 5;

   typedef struct packed {
      logic [31:0] duration_req;
      logic [1:0]  run_mode_req;
      logic [9:0]  flow_req;
      logic        inflate_req;
      logic [15:0] gas_level;
      logic [16:0] time_of_day_s;
      logic [31:0] now_ms;
   } item_type;

   typedef struct packed {
      logic [5:0] events;
      logic       link_up;
      logic       in_window;
      logic [1:0] run_mode_now;
      logic       inflating;
      logic       pump_running;
      logic       valve_open;
      logic [7:0] pump2_duty;
      logic [7:0] pump1_duty;
   } result_type;

endpackage

`default_nettype wire

### src/sampling_pump_sequencer.sv
// sampling pump sequencer: command and tick processing with result register
// an accepted word passes the input register, then the result register, to rsp
// throughput: one word per cycle while rsp is not held, set by the single state update stage
// the input register and result register both stall only when rsp is held
// synchronous active-high reset sets sequencer state, valid flags and csr regs
// to power-up values (not the data registers); csr writes are always accepted
`default_nettype none

module sampling_pump_sequencer
   import sps_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // now_ms, time_of_day_s, gas_level, inflate_req, flow_req, run_mode_req,
   // duration_req, zero fill
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,
   // command
   input  wire logic [REQ_USER_W-1:0]  req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // pump1_duty, pump2_duty, valve_open, pump_running, inflating,
   // run_mode_now, in_window, link_up, events, zero fill
   output logic [RSP_DATA_W-1:0]       rsp_tdata,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int unsigned ITEM_W = $bits(item_type);
   localparam int unsigned RESULT_W = $bits(result_type);

   // configuration
   logic [15:0] gas_threshold_ff;
   logic [16:0] window_start_ff;
   logic [16:0] window_end_ff;
   logic        dual_pump_ff;
   logic [31:0] link_timeout_ff;

   // input register
   logic        in_valid_ff;
   item_type    item_ff;
   cmd_type     cmd_ff;

   // result register
   logic        out_valid_ff;
   result_type  result_ff;

   // sequencer state
   logic         running_ff, running_in;
   logic         dir_inflate_ff, dir_inflate_in;
   logic [7:0]   flow_duty_ff, flow_duty_in;
   run_mode_type run_mode_ff, run_mode_in;
   logic [31:0]  start_ms_ff, start_ms_in;
   logic [31:0]  duration_ff, duration_in;
   logic         window_active_ff, window_active_in;
   logic [31:0]  last_sample_ff, last_sample_in;
   logic [31:0]  last_heartbeat_ff, last_heartbeat_in;
   logic         link_ok_ff, link_ok_in;
   logic [5:0]   events_in;
   result_type   result_in;

   logic         advance;

   assign advance = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {{(RSP_DATA_W - RESULT_W){1'b0}}, result_ff};
   assign csr_ready = 1'b1;

   always_comb begin
      logic [7:0]  flow_sat;
      logic [31:0] run_elapsed;
      logic        halted;
      logic        started;
      logic        hit;
      logic        inflate;

      flow_sat = (item_ff.flow_req > {2'b00, DUTY_MAX}) ? DUTY_MAX : item_ff.flow_req[7:0];
      run_elapsed = item_ff.now_ms - start_ms_ff;
      halted = 1'b0;
      started = 1'b0;
      hit = 1'b0;
      inflate = item_ff.inflate_req;

      running_in = running_ff;
      dir_inflate_in = dir_inflate_ff;
      flow_duty_in = flow_duty_ff;
      run_mode_in = run_mode_ff;
      start_ms_in = start_ms_ff;
      duration_in = duration_ff;
      window_active_in = window_active_ff;
      last_sample_in = last_sample_ff;
      last_heartbeat_in = last_heartbeat_ff;
      link_ok_in = link_ok_ff;
      events_in = '0;

      case (cmd_ff)
         CMD_TICK: begin
            link_ok_in = !((item_ff.now_ms - last_heartbeat_ff) > link_timeout_ff);
            // duration expiry
            if (running_ff && duration_ff != '0 && run_elapsed >= duration_ff) begin
               running_in = 1'b0;
               halted = 1'b1;
               events_in[EV_DURATION] = 1'b1;
               if (run_mode_ff != MODE_GAS && run_mode_ff != MODE_TIMED) begin
                  run_mode_in = MODE_OFF;
               end
            end
            // failsafe for continuous manual runs
            if (running_in && run_mode_in == MODE_MANUAL && duration_ff == '0 &&
                run_elapsed >= MANUAL_LIMIT_MS) begin
               running_in = 1'b0;
               halted = 1'b1;
               run_mode_in = MODE_OFF;
               events_in[EV_MANUAL_LIMIT] = 1'b1;
            end
            // gas auto start
            if (run_mode_in == MODE_GAS && !running_in &&
                item_ff.gas_level >= gas_threshold_ff) begin
               running_in = 1'b1;
               dir_inflate_in = 1'b1;
               started = 1'b1;
               events_in[EV_GAS_START] = 1'b1;
            end
            // daily window
            if (run_mode_in == MODE_TIMED) begin
               if (window_end_ff < window_start_ff) begin
                  hit = item_ff.time_of_day_s >= window_start_ff ||
                        item_ff.time_of_day_s <= window_end_ff;
               end else begin
                  hit = item_ff.time_of_day_s >= window_start_ff &&
                        item_ff.time_of_day_s <= window_end_ff;
               end
               if (hit && !window_active_ff) begin
                  window_active_in = 1'b1;
               end else if (!hit && window_active_ff) begin
                  window_active_in = 1'b0;
                  events_in[EV_WINDOW_EXIT] = 1'b1;
                  if (running_in) begin
                     running_in = 1'b0;
                     halted = 1'b1;
                  end
               end
               if (window_active_in && !running_in &&
                   (item_ff.now_ms - last_sample_ff) >= SAMPLE_GAP_MS) begin
                  last_sample_in = item_ff.now_ms;
                  running_in = 1'b1;
                  dir_inflate_in = 1'b1;
                  started = 1'b1;
                  events_in[EV_TIMED_START] = 1'b1;
               end
            end
            if (halted) begin
               duration_in = '0;
               start_ms_in = '0;
            end
            if (started) begin
               start_ms_in = item_ff.now_ms;
            end
         end
         CMD_START: begin
            if (!dual_pump_ff && !item_ff.inflate_req) begin
               inflate = 1'b1;
               events_in[EV_DEFLATE_REFUSED] = 1'b1;
            end
            dir_inflate_in = inflate;
            flow_duty_in = flow_sat;
            running_in = 1'b1;
            start_ms_in = item_ff.now_ms;
         end
         CMD_STOP: begin
            running_in = 1'b0;
            start_ms_in = '0;
            duration_in = '0;
         end
         CMD_ESTOP: begin
            running_in = 1'b0;
            start_ms_in = '0;
            duration_in = '0;
            run_mode_in = MODE_OFF;
            window_active_in = 1'b0;
         end
         CMD_FLOW: begin
            if (running_ff) begin
               flow_duty_in = flow_sat;
            end
         end
         CMD_RUN_MODE: begin
            run_mode_in = run_mode_type'(item_ff.run_mode_req);
         end
         CMD_DURATION: begin
            duration_in = item_ff.duration_req;
         end
         CMD_HEARTBEAT: begin
            last_heartbeat_in = item_ff.now_ms;
         end
         default: begin
            last_heartbeat_in = last_heartbeat_ff;
         end
      endcase

      result_in.pump1_duty = running_in ? flow_duty_in : '0;
      result_in.pump2_duty = (running_in && dual_pump_ff) ? flow_duty_in : '0;
      result_in.valve_open = running_in && dir_inflate_in;
      result_in.pump_running = running_in;
      result_in.inflating = dir_inflate_in;
      result_in.run_mode_now = run_mode_in;
      result_in.in_window = window_active_in;
      result_in.link_up = link_ok_in;
      result_in.events = events_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gas_threshold_ff <= 16'hFFFF;
         window_start_ff <= '0;
         window_end_ff <= '0;
         dual_pump_ff <= 1'b1;
         link_timeout_ff <= 32'd5000;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_GAS_THRESHOLD: gas_threshold_ff <= csr_data[15:0];
            CSR_WINDOW_START:  window_start_ff <= csr_data[16:0];
            CSR_WINDOW_END:    window_end_ff <= csr_data[16:0];
            CSR_DUAL_PUMP:     dual_pump_ff <= csr_data[0];
            CSR_LINK_TIMEOUT:  link_timeout_ff <= csr_data;
            default: begin
               link_timeout_ff <= link_timeout_ff;
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff <= item_type'(req_tdata[ITEM_W-1:0]);
         cmd_ff <= cmd_type'(req_tuser);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         dir_inflate_ff <= 1'b0;
         flow_duty_ff <= '0;
         run_mode_ff <= MODE_OFF;
         start_ms_ff <= '0;
         duration_ff <= '0;
         window_active_ff <= 1'b0;
         last_sample_ff <= '0;
         last_heartbeat_ff <= '0;
         link_ok_ff <= 1'b0;
      end else if (advance) begin
         running_ff <= running_in;
         dir_inflate_ff <= dir_inflate_in;
         flow_duty_ff <= flow_duty_in;
         run_mode_ff <= run_mode_in;
         start_ms_ff <= start_ms_in;
         duration_ff <= duration_in;
         window_active_ff <= window_active_in;
         last_sample_ff <= last_sample_in;
         last_heartbeat_ff <= last_heartbeat_in;
         link_ok_ff <= link_ok_in;
      end
   end

endmodule

`default_nettype wire

### dv/tb_sampling_pump_sequencer.sv
// self-checking testbench for the sampling pump sequencer with a status predictor
`timescale 1ns / 1ps

module tb_sampling_pump_sequencer;
   import sps_pkg::*;

   localparam int unsigned STUCK_LIMIT = 3000;
   localparam int unsigned QUIET_CYCLES = 6;
   localparam int unsigned PHASE_WORDS = 170;

   typedef struct {
      cmd_type  cmd;
      item_type body;
   } pump_cmd_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic [REQ_USER_W-1:0]  req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // register shadow, reset values
   logic [15:0] cfg_gas_thr = 16'hFFFF;
   logic [16:0] cfg_win_start = '0;
   logic [16:0] cfg_win_end = '0;
   logic        cfg_dual = 1'b1;
   logic [31:0] cfg_link_to = 32'd5000;

   // sequencer state as predicted
   logic         pump_on = 1'b0;
   logic         dir_inflate = 1'b0;
   logic [7:0]   flow_duty = '0;
   run_mode_type run_now = MODE_OFF;
   logic [31:0]  run_start_ms = '0;
   logic [31:0]  run_dur_ms = '0;
   logic         window_on = 1'b0;
   logic [31:0]  last_sample_ms = '0;
   logic [31:0]  last_hb_ms = '0;
   logic         link_ok = 1'b0;

   pump_cmd_type cmd_backlog[$];
   result_type   expected_status[$];
   pump_cmd_type next_cmd;
   int unsigned words_queued = 0;
   int unsigned req_offered = 0;
   int unsigned req_taken = 0;
   int unsigned status_seen = 0;
   int unsigned fail_count = 0;
   int unsigned req_gap = 0;
   int unsigned req_calm = 0;
   int unsigned rsp_stall = 0;
   int unsigned rsp_calm = 0;
   int unsigned rsp_hold = 0;
   int unsigned holds_done = 0;
   int unsigned stuck_cycles = 0;
   logic [31:0] sim_ms;
   int          sim_tod;

   sampling_pump_sequencer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   function automatic void halt_pump();
      pump_on = 1'b0;
      run_start_ms = '0;
      run_dur_ms = '0;
   endfunction

   function automatic void begin_pump(logic inflate, logic [7:0] duty, logic [31:0] now);
      dir_inflate = inflate;
      flow_duty = duty;
      pump_on = 1'b1;
      run_start_ms = now;
   endfunction

   function automatic result_type sequencer_step(cmd_type cmd, item_type it);
      result_type  r;
      logic [7:0]  duty;
      logic [5:0]  ev;
      logic [31:0] since_hb;
      logic        hit;
      logic        inflate;
      ev = '0;
      duty = (it.flow_req > 10'(DUTY_MAX)) ? DUTY_MAX : it.flow_req[7:0];
      case (cmd)
         CMD_TICK: begin
            since_hb = it.now_ms - last_hb_ms;
            link_ok = !(since_hb > cfg_link_to);
            if (pump_on && run_dur_ms != 0 && (it.now_ms - run_start_ms) >= run_dur_ms) begin
               halt_pump();
               ev[EV_DURATION] = 1'b1;
               if (run_now != MODE_GAS && run_now != MODE_TIMED) run_now = MODE_OFF;
            end
            if (pump_on && run_now == MODE_MANUAL && run_dur_ms == 0 &&
                (it.now_ms - run_start_ms) >= MANUAL_LIMIT_MS) begin
               halt_pump();
               run_now = MODE_OFF;
               ev[EV_MANUAL_LIMIT] = 1'b1;
            end
            if (run_now == MODE_GAS && !pump_on && it.gas_level >= cfg_gas_thr) begin
               begin_pump(1'b1, flow_duty, it.now_ms);
               ev[EV_GAS_START] = 1'b1;
            end
            if (run_now == MODE_TIMED) begin
               // a window whose end lies below its start crosses midnight
               if (cfg_win_end < cfg_win_start)
                  hit = it.time_of_day_s >= cfg_win_start || it.time_of_day_s <= cfg_win_end;
               else
                  hit = it.time_of_day_s >= cfg_win_start && it.time_of_day_s <= cfg_win_end;
               if (hit && !window_on) begin
                  window_on = 1'b1;
               end else if (!hit && window_on) begin
                  window_on = 1'b0;
                  ev[EV_WINDOW_EXIT] = 1'b1;
                  if (pump_on) halt_pump();
               end
               if (window_on && !pump_on && (it.now_ms - last_sample_ms) >= SAMPLE_GAP_MS) begin
                  last_sample_ms = it.now_ms;
                  begin_pump(1'b1, flow_duty, it.now_ms);
                  ev[EV_TIMED_START] = 1'b1;
               end
            end
         end
         CMD_START: begin
            inflate = it.inflate_req;
            if (!cfg_dual && !inflate) begin
               inflate = 1'b1;
               ev[EV_DEFLATE_REFUSED] = 1'b1;
            end
            begin_pump(inflate, duty, it.now_ms);
         end
         CMD_STOP: halt_pump();
         CMD_ESTOP: begin
            halt_pump();
            run_now = MODE_OFF;
            window_on = 1'b0;
         end
         CMD_FLOW: if (pump_on) flow_duty = duty;
         CMD_RUN_MODE: run_now = run_mode_type'(it.run_mode_req);
         CMD_DURATION: run_dur_ms = it.duration_req;
         default: last_hb_ms = it.now_ms;
      endcase
      r.pump1_duty = pump_on ? flow_duty : 8'd0;
      r.pump2_duty = (pump_on && cfg_dual) ? flow_duty : 8'd0;
      r.valve_open = pump_on && dir_inflate;
      r.pump_running = pump_on;
      r.inflating = dir_inflate;
      r.run_mode_now = run_now;
      r.in_window = window_on;
      r.link_up = link_ok;
      r.events = ev;
      return r;
   endfunction

   task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
      fail_count++;
      $display("word %0d: %s got %0h want %0h", status_seen, what, got, want);
   endtask

   task automatic check_status(result_type want, result_type got);
      if (got.pump1_duty !== want.pump1_duty)
         flag_mismatch("pump1_duty", got.pump1_duty, want.pump1_duty);
      if (got.pump2_duty !== want.pump2_duty)
         flag_mismatch("pump2_duty", got.pump2_duty, want.pump2_duty);
      if (got.valve_open !== want.valve_open)
         flag_mismatch("valve_open", got.valve_open, want.valve_open);
      if (got.pump_running !== want.pump_running)
         flag_mismatch("pump_running", got.pump_running, want.pump_running);
      if (got.inflating !== want.inflating)
         flag_mismatch("inflating", got.inflating, want.inflating);
      if (got.run_mode_now !== want.run_mode_now)
         flag_mismatch("run_mode_now", got.run_mode_now, want.run_mode_now);
      if (got.in_window !== want.in_window)
         flag_mismatch("in_window", got.in_window, want.in_window);
      if (got.link_up !== want.link_up)
         flag_mismatch("link_up", got.link_up, want.link_up);
      if (got.events !== want.events)
         flag_mismatch("events", got.events, want.events);
   endtask

   function automatic int unsigned pick_idle();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 50) return 0;
      if (r < 80) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 8);
      return $urandom_range(15, 60);
   endfunction

   function automatic item_type make_body(logic [31:0] now, logic [16:0] tod, logic [15:0] gas,
                                          logic infl, logic [9:0] flow, logic [1:0] rmode,
                                          logic [31:0] dur);
      item_type b;
      b.now_ms = now;
      b.time_of_day_s = tod;
      b.gas_level = gas;
      b.inflate_req = infl;
      b.flow_req = flow;
      b.run_mode_req = rmode;
      b.duration_req = dur;
      return b;
   endfunction

   function automatic item_type random_body();
      item_type    b;
      int unsigned r;
      int          g;
      r = $urandom_range(99);
      if (r < 60) sim_ms += $urandom_range(0, 3000);
      else if (r < 84) sim_ms += $urandom_range(3000, 120000);
      else if (r < 95) sim_ms += $urandom_range(120000, 700000);
      else if (r < 98) sim_ms += $urandom_range(1700000, 1900000);
      else sim_ms = $urandom();
      sim_tod = (sim_tod + int'($urandom_range(0, 400))) % 86400;
      b.now_ms = sim_ms;
      r = $urandom_range(99);
      if (r < 8) b.time_of_day_s = cfg_win_start + 17'($urandom_range(0, 2)) - 17'd1;
      else if (r < 16) b.time_of_day_s = cfg_win_end + 17'($urandom_range(0, 2)) - 17'd1;
      else if (r < 19) b.time_of_day_s = 17'($urandom_range(0, 131071));
      else b.time_of_day_s = 17'(sim_tod);
      r = $urandom_range(99);
      g = int'(cfg_gas_thr) + int'($urandom_range(0, 4)) - 2;
      if (r < 40) b.gas_level = 16'($urandom());
      else if (r < 85) b.gas_level = (g < 0) ? 16'd0 : (g > 65535) ? 16'hFFFF : 16'(g);
      else if (r < 92) b.gas_level = 16'd0;
      else b.gas_level = 16'hFFFF;
      b.inflate_req = 1'($urandom_range(1));
      r = $urandom_range(99);
      if (r < 8) b.flow_req = 10'd0;
      else if (r < 16) b.flow_req = 10'h3FF;
      else if (r < 30) b.flow_req = 10'($urandom_range(254, 256));
      else b.flow_req = 10'($urandom_range(0, 1023));
      b.run_mode_req = 2'($urandom_range(3));
      r = $urandom_range(99);
      if (r < 30) b.duration_req = 32'd0;
      else if (r < 40) b.duration_req = $urandom_range(0, 100);
      else if (r < 90) b.duration_req = $urandom_range(1000, 900000);
      else b.duration_req = $urandom();
      return b;
   endfunction

   task automatic queue_cmd(cmd_type c, item_type b);
      cmd_backlog.push_back('{cmd: c, body: b});
      words_queued++;
   endtask

   // a well-formed run in one of the modes, or a short burst of random commands
   task automatic queue_sequence();
      item_type    b;
      int unsigned kind;
      int unsigned r;
      kind = $urandom_range(99);
      if (kind < 20) begin
         repeat ($urandom_range(1, 4)) queue_cmd(cmd_type'($urandom_range(7)), random_body());
      end else begin
         if ($urandom_range(3) != 0) queue_cmd(CMD_HEARTBEAT, random_body());
         b = random_body();
         if (kind < 45) b.run_mode_req = MODE_MANUAL;
         else if (kind < 65) b.run_mode_req = MODE_GAS;
         else if (kind < 90) b.run_mode_req = MODE_TIMED;
         queue_cmd(CMD_RUN_MODE, b);
         if ($urandom_range(1) != 0) queue_cmd(CMD_DURATION, random_body());
         if (kind < 45 || kind >= 90 || $urandom_range(3) == 0)
            queue_cmd(CMD_START, random_body());
         if (kind >= 65 && kind < 90)
            sim_tod = (int'(cfg_win_start) + 86400 - int'($urandom_range(0, 600))) % 86400;
         repeat ($urandom_range(2, 9)) begin
            r = $urandom_range(9);
            if (r == 0) queue_cmd(CMD_FLOW, random_body());
            else if (r == 1) queue_cmd(CMD_HEARTBEAT, random_body());
            else queue_cmd(CMD_TICK, random_body());
         end
         r = $urandom_range(9);
         if (r < 2) queue_cmd(CMD_STOP, random_body());
         else if (r < 3) queue_cmd(CMD_ESTOP, random_body());
      end
   endtask

   task automatic wait_quiet();
      while (req_taken != words_queued || expected_status.size() != 0) @(negedge clock);
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_GAS_THRESHOLD: cfg_gas_thr = value[15:0];
         CSR_WINDOW_START: cfg_win_start = value[16:0];
         CSR_WINDOW_END: cfg_win_end = value[16:0];
         CSR_DUAL_PUMP: cfg_dual = value[0];
         CSR_LINK_TIMEOUT: cfg_link_to = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken == req_offered) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (cmd_backlog.size() != 0) begin
            next_cmd = cmd_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= next_cmd.cmd;
            req_tdata <= {{(REQ_DATA_W - $bits(item_type)){1'b0}}, next_cmd.body};
            req_offered++;
            if (req_calm > 0) begin
               req_calm--;
               req_gap = 0;
            end else begin
               req_gap = pick_idle();
               if ($urandom_range(49) == 0) req_calm = $urandom_range(20, 120);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // status receiver, with two long hold-offs so the input backs up
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else if (holds_done < 2 && status_seen >= 400 + 700 * holds_done) begin
         holds_done++;
         rsp_hold = 300;
         rsp_tready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (rsp_calm > 0) begin
            rsp_calm--;
         end else begin
            if ($urandom_range(2) == 0) rsp_stall = pick_idle();
            if ($urandom_range(49) == 0) rsp_calm = $urandom_range(20, 120);
         end
      end
   end

   // monitor: check returned status, predict status of accepted words
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            status_seen++;
            if (expected_status.size() == 0)
               flag_mismatch("unexpected word", rsp_tdata, 32'd0);
            else
               check_status(expected_status.pop_front(),
                            result_type'(rsp_tdata[$bits(result_type)-1:0]));
         end
         if (req_tvalid && req_tready) begin
            expected_status.push_back(sequencer_step(cmd_type'(req_tuser),
                                                     item_type'(req_tdata[$bits(item_type)-1:0])));
            req_taken++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      logic [16:0] ws;
      logic [16:0] we;
      int unsigned target;
      sim_ms = $urandom();
      sim_tod = $urandom_range(0, 86399);
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: saturation, zero flow, link loss, failsafe, expiry, auto starts, wrap
      queue_cmd(CMD_TICK, make_body(32'd0, 17'd0, 16'd0, 1'b0, 10'd0, MODE_OFF, 32'd0));
      queue_cmd(CMD_HEARTBEAT, make_body(32'd100, 17'h1FFFF, 16'hFFFF, 1'b1, 10'h3FF,
                                         MODE_TIMED, 32'hFFFF_FFFF));
      queue_cmd(CMD_START, make_body(32'd200, 17'd5, 16'd0, 1'b0, 10'h3FF, MODE_OFF, 32'd0));
      queue_cmd(CMD_FLOW, make_body(32'd300, 17'd5, 16'd0, 1'b1, 10'd0, MODE_OFF, 32'd0));
      queue_cmd(CMD_TICK, make_body(32'd10000, 17'd5, 16'd0, 1'b0, 10'd0, MODE_OFF, 32'd0));
      queue_cmd(CMD_STOP, make_body(32'd10100, 17'd5, 16'd0, 1'b0, 10'd0, MODE_OFF, 32'd0));
      queue_cmd(CMD_FLOW, make_body(32'd10200, 17'd5, 16'd0, 1'b0, 10'd77, MODE_OFF, 32'd0));
      queue_cmd(CMD_RUN_MODE, make_body(32'd10300, 17'd5, 16'd0, 1'b0, 10'd0,
                                        MODE_MANUAL, 32'd0));
      queue_cmd(CMD_START, make_body(32'd20000, 17'd5, 16'd0, 1'b1, 10'd300, MODE_OFF, 32'd0));
      queue_cmd(CMD_TICK, make_body(32'd1819999, 17'd5, 16'd0, 1'b0, 10'd0, MODE_OFF, 32'd0));
      queue_cmd(CMD_TICK, make_body(32'd1820000, 17'd5, 16'd0, 1'b0, 10'd0, MODE_OFF, 32'd0));
      queue_cmd(CMD_DURATION, make_body(32'd1820100, 17'd5, 16'd0, 1'b0, 10'd0,
                                        MODE_OFF, 32'd1000));
      queue_cmd(CMD_RUN_MODE, make_body(32'd1820200, 17'd5, 16'd0, 1'b0, 10'd0,
                                        MODE_MANUAL, 32'd0));
      queue_cmd(CMD_START, make_body(32'd3000000, 17'd5, 16'd0, 1'b1, 10'd10, MODE_OFF, 32'd0));
      queue_cmd(CMD_TICK, make_body(32'd3001000, 17'd5, 16'd0, 1'b0, 10'd0, MODE_OFF, 32'd0));
      queue_cmd(CMD_RUN_MODE, make_body(32'd3001100, 17'd5, 16'd0, 1'b0, 10'd0,
                                        MODE_GAS, 32'd0));
      queue_cmd(CMD_TICK, make_body(32'd3002000, 17'd5, 16'hFFFF, 1'b0, 10'd0,
                                    MODE_OFF, 32'd0));
      queue_cmd(CMD_ESTOP, make_body(32'd3002500, 17'd5, 16'd0, 1'b0, 10'd0, MODE_OFF, 32'd0));
      queue_cmd(CMD_RUN_MODE, make_body(32'd3002600, 17'd5, 16'd0, 1'b0, 10'd0,
                                        MODE_TIMED, 32'd0));
      queue_cmd(CMD_TICK, make_body(32'd3100000, 17'd0, 16'd0, 1'b0, 10'd0, MODE_OFF, 32'd0));
      queue_cmd(CMD_TICK, make_body(32'd3100500, 17'h1FFFF, 16'd0, 1'b0, 10'd0,
                                    MODE_OFF, 32'd0));
      queue_cmd(CMD_HEARTBEAT, make_body(32'hFFFF_FF00, 17'd0, 16'd0, 1'b0, 10'd0,
                                         MODE_OFF, 32'd0));
      queue_cmd(CMD_TICK, make_body(32'd100, 17'd86399, 16'hFFFF, 1'b0, 10'd0,
                                    MODE_OFF, 32'd0));
      queue_cmd(CMD_DURATION, make_body(32'hFFFF_FFFF, 17'd0, 16'd0, 1'b0, 10'd0,
                                        MODE_OFF, 32'hFFFF_FFFF));
      wait_quiet();

      // single pump build refuses deflate, window wraps midnight
      write_csr(CSR_DUAL_PUMP, 32'd0);
      write_csr(CSR_GAS_THRESHOLD, 32'd0);
      write_csr(CSR_WINDOW_START, 32'd100);
      write_csr(CSR_WINDOW_END, 32'd50);
      write_csr(CSR_LINK_TIMEOUT, 32'd0);
      queue_cmd(CMD_START, make_body(32'd5000, 17'd100, 16'd0, 1'b0, 10'd512, MODE_OFF, 32'd0));
      queue_cmd(CMD_TICK, make_body(32'd5000, 17'd100, 16'd0, 1'b0, 10'd0, MODE_OFF, 32'd0));
      wait_quiet();

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: write_csr(CSR_GAS_THRESHOLD, 32'd0);
            1: write_csr(CSR_GAS_THRESHOLD, 32'hFFFF);
            default: write_csr(CSR_GAS_THRESHOLD, (p % 2 != 0) ? $urandom_range(20000, 40000)
                                                               : $urandom_range(0, 65535));
         endcase
         case (p)
            2: begin
               ws = 17'd86399;
               we = 17'd0;
            end
            3: begin
               ws = 17'd0;
               we = 17'd86399;
            end
            5: begin
               ws = 17'h1FFFF;
               we = 17'h1FFFF;
            end
            default: begin
               ws = 17'($urandom_range(0, 86399));
               we = 17'((int'(ws) + int'($urandom_range(60, 7200))) % 86400);
            end
         endcase
         write_csr(CSR_WINDOW_START, 32'(ws));
         write_csr(CSR_WINDOW_END, 32'(we));
         write_csr(CSR_DUAL_PUMP, 32'(p % 2));
         case (p)
            1: write_csr(CSR_LINK_TIMEOUT, 32'd0);
            2: write_csr(CSR_LINK_TIMEOUT, 32'hFFFF_FFFF);
            default: write_csr(CSR_LINK_TIMEOUT, $urandom_range(2000, 400000));
         endcase
         target = words_queued + PHASE_WORDS;
         while (words_queued < target) queue_sequence();
         wait_quiet();
      end

      if (expected_status.size() != 0)
         flag_mismatch("words never returned", expected_status.size(), 32'd0);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### sampling_pump_sequencer.f
src/sps_pkg.sv
src/sampling_pump_sequencer.sv
dv/tb_sampling_pump_sequencer.sv
